FILE: sv/sspq_pkg.sv
// shared constants, codes and state type of the stable sorted priority queue
`default_nettype none

package sspq_pkg;

	// default sizes of the storage
	localparam int DEF_QUEUE_DEPTH   = 16;
	localparam int DEF_PRIORITY_BITS = 8;
	localparam int DEF_HANDLE_BITS   = 16;

	// fixed widths of the word fields
	localparam int OP_W     = 1;
	localparam int PRI_W    = 8;
	localparam int HND_W    = 16;
	localparam int COUNT_W  = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_ENQUEUE = 1'b0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ_RD,
		ST_ENQ_CMP,
		ST_DEQ_RD,
		ST_DEQ_WB,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: sv/stable_sorted_priority_queue.sv
// stable sorted priority queue with a sequenced single-port sorted store
`default_nettype none

// an enqueue reads and compares each entry that it moves back, and a dequeue reads and moves
//   every stored entry; a refused word goes straight from accept to result
// one word is worked on at a time; the single read and write port of the slot memory
//   and the compare unit set the pace, a read and a write for each moved entry
// reset: arst_n clears the entry count, the sequencer and the result valid;
//   slot memory contents are not cleared, only slots below the count are read
module stable_sorted_priority_queue #(
	parameter int QUEUE_DEPTH   = sspq_pkg::DEF_QUEUE_DEPTH,
	parameter int PRIORITY_BITS = sspq_pkg::DEF_PRIORITY_BITS,
	parameter int HANDLE_BITS   = sspq_pkg::DEF_HANDLE_BITS
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// command channel
	input  wire                             cmd_valid,
	output logic                            cmd_stall,
	input  wire  [sspq_pkg::OP_W-1:0]       operation,
	input  wire  [sspq_pkg::PRI_W-1:0]      entry_priority,
	input  wire  [sspq_pkg::HND_W-1:0]      entry_handle,
	// response channel
	output logic                            rsp_valid,
	input  wire                             rsp_stall,
	output logic                            accepted,
	output logic [sspq_pkg::HND_W-1:0]      out_handle,
	output logic [sspq_pkg::PRI_W-1:0]      out_priority,
	output logic [sspq_pkg::COUNT_W-1:0]    entry_count
);

	import sspq_pkg::*;

	// slot index and entry count widths
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	// one slot holds priority above handle
	localparam int ENT_W = PRIORITY_BITS + HANDLE_BITS;

	// sequencer and control registers
	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q;    // stored entries
	logic [CNT_W-1:0]     pos_q;      // walking slot position
	logic [OP_W-1:0]      op_q;
	logic                 ok_q;

	// the word being worked on
	logic [PRIORITY_BITS-1:0] new_pri_q;
	logic [HANDLE_BITS-1:0]   new_hnd_q;
	logic [PRIORITY_BITS-1:0] front_pri_q;
	logic [HANDLE_BITS-1:0]   front_hnd_q;

	// response register
	logic                 rsp_valid_q;
	logic                 rsp_ok_q;
	logic [HND_W-1:0]     rsp_hnd_q;
	logic [PRI_W-1:0]     rsp_pri_q;
	logic [COUNT_W-1:0]   rsp_cnt_q;

	// slot memory, one write and one registered read per cycle
	logic [ENT_W-1:0]     slot_mem [QUEUE_DEPTH];
	logic [ENT_W-1:0]     rd_q;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [ENT_W-1:0]     mem_wdata;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_raddr;

	// decoded helpers
	logic                 cmd_take;
	logic                 rsp_load;
	logic [CNT_W-1:0]     pos_dec;
	logic [CNT_W-1:0]     pos_inc;
	logic [PRIORITY_BITS-1:0] rd_pri;
	logic                 shift_back;   // shared compare: stored entry ranks below new one
	logic [CNT_W-1:0]     count_next;

	assign cmd_take   = cmd_valid && !cmd_stall;
	assign rsp_load   = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign pos_dec    = pos_q - CNT_W'(1);
	assign pos_inc    = pos_q + CNT_W'(1);
	assign rd_pri     = rd_q[ENT_W-1 -: PRIORITY_BITS];
	assign shift_back = rd_pri < new_pri_q;

	// count after the finished word
	always_comb begin
		count_next = count_q;
		if (ok_q) begin
			if (op_q == OP_ENQUEUE) begin
				count_next = count_q + CNT_W'(1);
			end else begin
				count_next = count_q - CNT_W'(1);
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port control
	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = pos_q[IDX_W-1:0];
		mem_wdata = {new_pri_q, new_hnd_q};
		mem_re    = 1'b0;
		mem_raddr = pos_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					if (operation == OP_ENQUEUE) begin
						// full queue refuses the word
						state_d = (count_q == CNT_W'(QUEUE_DEPTH)) ? ST_DONE : ST_ENQ_RD;
					end else begin
						state_d = (count_q == '0) ? ST_DONE : ST_DEQ_RD;
					end
				end
			end
			ST_ENQ_RD: begin
				if (pos_q == '0) begin
					// reached the front, new entry goes to slot zero
					mem_we  = 1'b1;
					state_d = ST_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = pos_dec[IDX_W-1:0];
					state_d   = ST_ENQ_CMP;
				end
			end
			ST_ENQ_CMP: begin
				mem_we = 1'b1;
				if (shift_back) begin
					// move the lower ranked entry back one slot
					mem_wdata = rd_q;
					state_d   = ST_ENQ_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DEQ_RD: begin
				mem_re  = 1'b1;
				state_d = ST_DEQ_WB;
			end
			ST_DEQ_WB: begin
				if (pos_q != '0) begin
					// move entry forward one slot
					mem_we    = 1'b1;
					mem_waddr = pos_dec[IDX_W-1:0];
					mem_wdata = rd_q;
				end
				state_d = (pos_inc == count_q) ? ST_DONE : ST_DEQ_RD;
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			op_q    <= OP_ENQUEUE;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						op_q <= operation;
						if (operation == OP_ENQUEUE) begin
							ok_q  <= (count_q != CNT_W'(QUEUE_DEPTH));
							pos_q <= count_q;
						end else begin
							ok_q  <= (count_q != '0);
							pos_q <= '0;
						end
					end
				end
				ST_ENQ_CMP: begin
					if (shift_back) begin
						pos_q <= pos_dec;
					end
				end
				ST_DEQ_WB: begin
					pos_q <= pos_inc;
				end
				ST_DONE: begin
					if (rsp_load) begin
						count_q <= count_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// word payload and dequeued front entry
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			new_pri_q <= PRIORITY_BITS'(entry_priority);
			new_hnd_q <= HANDLE_BITS'(entry_handle);
		end
		if (state_q == ST_DEQ_WB && pos_q == '0) begin
			front_pri_q <= rd_pri;
			front_hnd_q <= rd_q[HANDLE_BITS-1:0];
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= slot_mem[mem_raddr];
		end
	end

	// response register, held while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_ok_q  <= ok_q;
			rsp_cnt_q <= COUNT_W'(count_next);
			// only a successful dequeue returns an entry
			if (ok_q && op_q == OP_DEQUEUE) begin
				rsp_hnd_q <= HND_W'(front_hnd_q);
				rsp_pri_q <= PRI_W'(front_pri_q);
			end else begin
				rsp_hnd_q <= '0;
				rsp_pri_q <= '0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign accepted     = rsp_ok_q;
	assign out_handle   = rsp_hnd_q;
	assign out_priority = rsp_pri_q;
	assign entry_count  = rsp_cnt_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mem_we && !mem_re)
		else $error("slot memory accessed while idle");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("response raised outside the finish step");

	a_cmp_not_front: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ENQ_CMP |-> pos_q != '0)
		else $error("insert compare at the front slot");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENQ_RD || state_q == ST_DEQ_RD) |-> pos_q <= count_q)
		else $error("slot walk beyond the stored entries");

endmodule

`default_nettype wire
